>>> rtl/core/dsw_pkg.sv
// shared types, constants and tables of the dice sum ways counter
`default_nettype none
package dsw_pkg;

   localparam int MaxSides  = 32;
   localparam int MaxDice   = 8;
   localparam int SidesW    = 6;
   localparam int DiceW     = 4;
   localparam int SumW      = 8;
   localparam int OutW      = 41;
   localparam int ValW      = 56;
   localparam int AccW      = 58;
   localparam int OpndW     = 8;
   localparam int DivW      = 13;
   localparam int RemW      = 14;
   localparam int DivBits   = 4;
   localparam int DivSteps  = ValW / DivBits;
   localparam int DivCntW   = 4;
   localparam int SkW       = 9;

   // register byte addresses
   localparam logic [2:0] AddrSides = 3'd0;
   localparam logic [2:0] AddrDice  = 3'd4;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ONE,
      OP_MUL,
      OP_DIV_FIRST,
      OP_DIV,
      OP_ACC
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [OpndW-1:0]  opnd;
      logic [DivW-1:0]   divisor;
      logic              sub;
   } cmd_type;

   typedef struct packed {
      logic [ValW-1:0]   val;
      logic [AccW-1:0]   acc;
   } stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TOT_INIT,
      ST_TOT_MUL,
      ST_TERM_CHK,
      ST_PROD_MUL,
      ST_DIV,
      ST_COEF_MUL,
      ST_ACCUM,
      ST_DONE
   } state_type;

   // binomial coefficients C(n,k), row n of nine entries
   localparam logic [7:0] BINOM_TAB [0:80] = '{
      8'd1, 8'd0, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0,
      8'd1, 8'd1, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0,
      8'd1, 8'd2, 8'd1,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0,
      8'd1, 8'd3, 8'd3,  8'd1,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0,
      8'd1, 8'd4, 8'd6,  8'd4,  8'd1,  8'd0,  8'd0,  8'd0, 8'd0,
      8'd1, 8'd5, 8'd10, 8'd10, 8'd5,  8'd1,  8'd0,  8'd0, 8'd0,
      8'd1, 8'd6, 8'd15, 8'd20, 8'd15, 8'd6,  8'd1,  8'd0, 8'd0,
      8'd1, 8'd7, 8'd21, 8'd35, 8'd35, 8'd21, 8'd7,  8'd1, 8'd0,
      8'd1, 8'd8, 8'd28, 8'd56, 8'd70, 8'd56, 8'd28, 8'd8, 8'd1
   };

   localparam logic [DivW-1:0] FACT_TAB [0:7] = '{
      13'd1, 13'd1, 13'd2, 13'd6, 13'd24, 13'd120, 13'd720, 13'd5040
   };

   function automatic logic [7:0] binom(input logic [DiceW-1:0] n, input logic [DiceW-1:0] k);
      logic [6:0] idx;
      idx = {n, 3'b000} + {3'b000, n} + {3'b000, k};
      return BINOM_TAB[idx];
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/dsw_unit.sv
// shared multiply, exact-divide and accumulate unit
`default_nettype none
module dsw_unit (
   input  wire logic              clock,
   input  wire dsw_pkg::cmd_type  cmd,
   output dsw_pkg::stat_type      stat
);

   logic [dsw_pkg::ValW-1:0] val_ff, val_in;
   logic [dsw_pkg::RemW-1:0] rem_ff, rem_in;
   logic [dsw_pkg::AccW-1:0] acc_ff, acc_in;
   logic [dsw_pkg::ValW+dsw_pkg::OpndW-1:0] prod;
   logic [dsw_pkg::RemW-1:0] r;
   logic [dsw_pkg::ValW-1:0] q;
   logic [dsw_pkg::AccW-1:0] val_ext;

   always_comb begin
      prod    = val_ff * cmd.opnd;
      val_ext = {{(dsw_pkg::AccW-dsw_pkg::ValW){1'b0}}, val_ff};
      r       = (cmd.op == dsw_pkg::OP_DIV_FIRST) ? '0 : rem_ff;
      q       = val_ff;
      // four restoring quotient bits a cycle
      for (int i = 0; i < dsw_pkg::DivBits; i++) begin
         r = {r[dsw_pkg::RemW-2:0], q[dsw_pkg::ValW-1]};
         q = {q[dsw_pkg::ValW-2:0], 1'b0};
         if (r >= {1'b0, cmd.divisor}) begin
            r    = r - {1'b0, cmd.divisor};
            q[0] = 1'b1;
         end
      end
      val_in = val_ff;
      rem_in = rem_ff;
      acc_in = acc_ff;
      unique case (cmd.op)
         dsw_pkg::OP_CLEAR: begin
            val_in = {{(dsw_pkg::ValW-1){1'b0}}, 1'b1};
            acc_in = '0;
         end
         dsw_pkg::OP_ONE: begin
            val_in = {{(dsw_pkg::ValW-1){1'b0}}, 1'b1};
         end
         dsw_pkg::OP_MUL: begin
            val_in = prod[dsw_pkg::ValW-1:0];
         end
         dsw_pkg::OP_DIV_FIRST, dsw_pkg::OP_DIV: begin
            val_in = q;
            rem_in = r;
         end
         dsw_pkg::OP_ACC: begin
            acc_in = cmd.sub ? (acc_ff - val_ext) : (acc_ff + val_ext);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign stat.val = val_ff;
   assign stat.acc = acc_ff;

endmodule
`default_nettype wire

>>> rtl/core/dsw_seq.sv
// sequencer driving the shared unit through the alternating binomial sum
`default_nettype none
module dsw_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [dsw_pkg::SumW-1:0]      target,
   input  wire logic [dsw_pkg::SidesW-1:0]    sides_eff,
   input  wire logic [dsw_pkg::DiceW-1:0]     dice_eff,
   input  wire logic                          out_busy,
   input  wire dsw_pkg::stat_type             stat,
   output dsw_pkg::cmd_type                   cmd,
   output logic                               busy,
   output logic                               done,
   output logic [dsw_pkg::OutW-1:0]           ways,
   output logic [dsw_pkg::OutW-1:0]           total,
   output logic                               in_range
);

   dsw_pkg::state_type state_ff, state_in;
   logic [dsw_pkg::SumW-1:0]   t_ff, t_in;
   logic [dsw_pkg::SidesW-1:0] s_ff, s_in;
   logic [dsw_pkg::DiceW-1:0]  n_ff, n_in;
   logic                       ok_ff, ok_in;
   logic [dsw_pkg::DiceW-1:0]  k_ff, k_in;
   logic [dsw_pkg::DiceW-1:0]  cnt_ff, cnt_in;
   logic [dsw_pkg::SkW-1:0]    sk_ff, sk_in;
   logic [dsw_pkg::SumW-1:0]   m_ff, m_in;
   logic [dsw_pkg::DivCntW-1:0] dc_ff, dc_in;
   logic [dsw_pkg::OutW-1:0]   total_ff, total_in;
   logic [2:0]                 r;
   logic [dsw_pkg::SkW:0]      span;
   logic [dsw_pkg::SkW:0]      lim;
   logic [dsw_pkg::SkW:0]      mw;
   logic [dsw_pkg::SkW-1:0]    sn;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      s_ff     <= s_in;
      n_ff     <= n_in;
      ok_ff    <= ok_in;
      k_ff     <= k_in;
      cnt_ff   <= cnt_in;
      sk_ff    <= sk_in;
      m_ff     <= m_in;
      dc_ff    <= dc_in;
      total_ff <= total_in;
   end

   always_comb begin
      r    = 3'(n_ff - 4'd1);
      sn   = 9'(sides_eff * dice_eff);
      span = {1'b0, sk_ff} + {{(dsw_pkg::SkW+1-dsw_pkg::DiceW){1'b0}}, n_ff};
      lim  = {{(dsw_pkg::SkW+1-dsw_pkg::SumW){1'b0}}, t_ff};
      mw   = lim - {1'b0, sk_ff} - 10'd1;
      state_in = state_ff;
      t_in     = t_ff;
      s_in     = s_ff;
      n_in     = n_ff;
      ok_in    = ok_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      sk_in    = sk_ff;
      m_in     = m_ff;
      dc_in    = dc_ff;
      total_in = total_ff;
      cmd.op      = dsw_pkg::OP_NONE;
      cmd.opnd    = '0;
      cmd.divisor = dsw_pkg::FACT_TAB[r];
      cmd.sub     = k_ff[0];
      done        = 1'b0;
      unique case (state_ff)
         dsw_pkg::ST_IDLE: begin
            if (start) begin
               t_in  = target;
               s_in  = sides_eff;
               n_in  = dice_eff;
               ok_in = ({1'b0, target} >= {5'd0, dice_eff}) && ({1'b0, target} <= sn);
               state_in = dsw_pkg::ST_TOT_INIT;
            end
         end
         dsw_pkg::ST_TOT_INIT: begin
            cmd.op   = dsw_pkg::OP_CLEAR;
            cnt_in   = '0;
            k_in     = '0;
            sk_in    = '0;
            state_in = dsw_pkg::ST_TOT_MUL;
         end
         dsw_pkg::ST_TOT_MUL: begin
            if (cnt_ff == n_ff) begin
               total_in = stat.val[dsw_pkg::OutW-1:0];
               state_in = dsw_pkg::ST_TERM_CHK;
            end else begin
               cmd.op   = dsw_pkg::OP_MUL;
               cmd.opnd = {2'b00, s_ff};
               cnt_in   = cnt_ff + 4'd1;
            end
         end
         dsw_pkg::ST_TERM_CHK: begin
            // a term exists while target - s*k still reaches n
            if (!ok_ff || (k_ff > n_ff) || (lim < span)) begin
               state_in = dsw_pkg::ST_DONE;
            end else begin
               m_in     = mw[dsw_pkg::SumW-1:0];
               cnt_in   = '0;
               cmd.op   = dsw_pkg::OP_ONE;
               state_in = dsw_pkg::ST_PROD_MUL;
            end
         end
         dsw_pkg::ST_PROD_MUL: begin
            // falling product m(m-1)..(m-r+1)
            if (cnt_ff[2:0] == r) begin
               dc_in    = '0;
               state_in = dsw_pkg::ST_DIV;
            end else begin
               cmd.op   = dsw_pkg::OP_MUL;
               cmd.opnd = m_ff - {5'd0, cnt_ff[2:0]};
               cnt_in   = cnt_ff + 4'd1;
            end
         end
         dsw_pkg::ST_DIV: begin
            // exact division by r factorial
            cmd.op = (dc_ff == '0) ? dsw_pkg::OP_DIV_FIRST : dsw_pkg::OP_DIV;
            dc_in  = dc_ff + 4'd1;
            if (dc_ff == 4'(dsw_pkg::DivSteps - 1)) begin
               state_in = dsw_pkg::ST_COEF_MUL;
            end
         end
         dsw_pkg::ST_COEF_MUL: begin
            cmd.op   = dsw_pkg::OP_MUL;
            cmd.opnd = dsw_pkg::binom(n_ff, k_ff);
            state_in = dsw_pkg::ST_ACCUM;
         end
         dsw_pkg::ST_ACCUM: begin
            cmd.op   = dsw_pkg::OP_ACC;
            k_in     = k_ff + 4'd1;
            sk_in    = sk_ff + {3'd0, s_ff};
            state_in = dsw_pkg::ST_TERM_CHK;
         end
         dsw_pkg::ST_DONE: begin
            if (!out_busy) begin
               done     = 1'b1;
               state_in = dsw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dsw_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy     = (state_ff != dsw_pkg::ST_IDLE);
   assign ways     = ok_ff ? stat.acc[dsw_pkg::OutW-1:0] : '0;
   assign total    = total_ff;
   assign in_range = ok_ff;

endmodule
`default_nettype wire

>>> rtl/core/dice_sum_ways_count_core.sv
// top level: register port, input beat capture, sequencer, unit and result register
// order of work: sides^n after the beat is taken, then each term in turn, at most n terms,
//   then the last term check and the load of the result register
// throughput: one item at a time, the next beat taken once the result has loaded
// reset: synchronous, active high; sides returns to 6, dice_count to 2, no result pending
`default_nettype none
module dice_sum_ways_count_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [dsw_pkg::SumW-1:0]    req_target_sum,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [dsw_pkg::OutW-1:0]         rsp_ways,
   output logic [dsw_pkg::OutW-1:0]         rsp_total_outcomes,
   output logic                             rsp_in_range,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [2:0]                  csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   // configuration registers
   logic [dsw_pkg::SidesW-1:0] sides_ff, sides_in;
   logic [dsw_pkg::DiceW-1:0]  dice_ff, dice_in;
   logic                       wr_en;

   // clamped settings seen by the sequencer
   logic [dsw_pkg::SidesW-1:0] sides_eff;
   logic [dsw_pkg::DiceW-1:0]  dice_eff;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [dsw_pkg::OutW-1:0]   ways_ff, ways_in;
   logic [dsw_pkg::OutW-1:0]   total_ff, total_in;
   logic                       range_ff, range_in;

   dsw_pkg::cmd_type  cmd;
   dsw_pkg::stat_type stat;
   logic                       busy;
   logic                       done;
   logic                       start;
   logic                       out_busy;
   logic [dsw_pkg::OutW-1:0]   seq_ways;
   logic [dsw_pkg::OutW-1:0]   seq_total;
   logic                       seq_range;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // register 0 at byte 0, register 1 at byte 4
   always_comb begin
      sides_in = sides_ff;
      dice_in  = dice_ff;
      if (wr_en) begin
         if (csr_paddr[2] == dsw_pkg::AddrDice[2]) begin
            dice_in = csr_pwdata[dsw_pkg::DiceW-1:0];
         end else begin
            sides_in = csr_pwdata[dsw_pkg::SidesW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sides_ff <= 6'd6;
         dice_ff  <= 4'd2;
      end else begin
         sides_ff <= sides_in;
         dice_ff  <= dice_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == dsw_pkg::AddrDice[2]) ? {28'd0, dice_ff}
                                                              : {26'd0, sides_ff};

   // zero is taken as one, anything past the limit as the limit
   always_comb begin
      if (sides_ff == '0) begin
         sides_eff = 6'd1;
      end else if (sides_ff > 6'(dsw_pkg::MaxSides)) begin
         sides_eff = 6'(dsw_pkg::MaxSides);
      end else begin
         sides_eff = sides_ff;
      end
      if (dice_ff == '0) begin
         dice_eff = 4'd1;
      end else if (dice_ff > 4'(dsw_pkg::MaxDice)) begin
         dice_eff = 4'(dsw_pkg::MaxDice);
      end else begin
         dice_eff = dice_ff;
      end
   end

   // a new beat is taken whenever the sequencer is idle, even with a result waiting
   assign req_stall = busy;
   assign start     = req_valid & ~busy;
   assign out_busy  = rsp_valid_ff & rsp_stall;

   dsw_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .target    (req_target_sum),
      .sides_eff (sides_eff),
      .dice_eff  (dice_eff),
      .out_busy  (out_busy),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .done      (done),
      .ways      (seq_ways),
      .total     (seq_total),
      .in_range  (seq_range)
   );

   dsw_unit u_unit (
      .clock (clock),
      .cmd   (cmd),
      .stat  (stat)
   );

   // result register holds until the beat is taken
   always_comb begin
      rsp_valid_in = out_busy | done;
      ways_in      = ways_ff;
      total_in     = total_ff;
      range_in     = range_ff;
      if (done) begin
         ways_in  = seq_ways;
         total_in = seq_total;
         range_in = seq_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ways_ff  <= ways_in;
      total_ff <= total_in;
      range_ff <= range_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ways           = ways_ff;
   assign rsp_total_outcomes = total_ff;
   assign rsp_in_range       = range_ff;

endmodule
`default_nettype wire

>>> tb/dsw_checker.sv
// checker: watches config writes and both channels, predicts ways and compares
module dsw_checker (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_stall,
   input  wire logic [dsw_pkg::SumW-1:0]  req_target_sum,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire logic [dsw_pkg::OutW-1:0]  rsp_ways,
   input  wire logic [dsw_pkg::OutW-1:0]  rsp_total_outcomes,
   input  wire logic                      rsp_in_range,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [2:0]                csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output int                             fail_count,
   output int                             pending
);

   typedef struct packed {
      logic [dsw_pkg::OutW-1:0] ways;
      logic [dsw_pkg::OutW-1:0] total;
      logic                     in_range;
   } roll_result_type;

   logic [dsw_pkg::SidesW-1:0] sides_reg;
   logic [dsw_pkg::DiceW-1:0]  dice_reg;
   roll_result_type            expected_rolls [$];

   // convolution count of ordered rolls, kept 64 bits and masked on output
   function automatic roll_result_type predict_roll(input logic [dsw_pkg::SumW-1:0] t);
      roll_result_type r;
      longint unsigned cur [0:255];
      longint unsigned nxt [0:255];
      longint unsigned acc;
      longint unsigned tot;
      int s, n;
      s = (sides_reg == 0) ? 1
          : (sides_reg > dsw_pkg::MaxSides ? dsw_pkg::MaxSides : sides_reg);
      n = (dice_reg == 0) ? 1 : (dice_reg > dsw_pkg::MaxDice ? dsw_pkg::MaxDice : dice_reg);
      tot = 1;
      for (int i = 0; i < n; i++) tot = tot * s;
      r.total = tot[dsw_pkg::OutW-1:0];
      r.in_range = (t >= n) && (t <= s * n);
      r.ways = '0;
      if (r.in_range) begin
         for (int v = 0; v < 256; v++) cur[v] = 0;
         cur[0] = 1;
         for (int d = 0; d < n; d++) begin
            for (int v = 0; v < 256; v++) begin
               acc = 0;
               for (int f = 1; f <= s && f <= v; f++) acc += cur[v-f];
               nxt[v] = (v <= t) ? acc : 0;
            end
            cur = nxt;
         end
         r.ways = cur[t][dsw_pkg::OutW-1:0];
      end
      return r;
   endfunction

   assign pending = expected_rolls.size();

   always @(posedge clock) begin
      roll_result_type e;
      if (reset) begin
         sides_reg <= 6'd6;
         dice_reg  <= 4'd2;
         expected_rolls.delete();
         fail_count <= 0;
      end else begin
         // register write lands on the access phase; bit 2 of the address picks it
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == dsw_pkg::AddrDice[2]) dice_reg <= csr_pwdata[dsw_pkg::DiceW-1:0];
            else sides_reg <= csr_pwdata[dsw_pkg::SidesW-1:0];
         end
         if (req_valid && !req_stall) expected_rolls.push_back(predict_roll(req_target_sum));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rolls.size() == 0) begin
               if (fail_count < 10) $display("unexpected result beat ways=%0d", rsp_ways);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_rolls.pop_front();
               if (e.ways !== rsp_ways || e.total !== rsp_total_outcomes
                   || e.in_range !== rsp_in_range) begin
                  if (fail_count < 10)
                     $display("mismatch: ways %0d/%0d total %0d/%0d in_range %0d/%0d",
                              e.ways, rsp_ways, e.total, rsp_total_outcomes,
                              e.in_range, rsp_in_range);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

>>> tb/tb_dice_sum_ways_count_core.sv
// testbench top: stimulus, register phases, stalls and the verdict
module tb_dice_sum_ways_count_core;

   localparam int SettleCycles = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [dsw_pkg::SumW-1:0] req_target_sum = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [dsw_pkg::OutW-1:0] rsp_ways, rsp_total_outcomes;
   logic rsp_in_range;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   int fail_count, pending;
   logic hold_off = 1'b0;   // forces a long receiver stall

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   dice_sum_ways_count_core u_top (.*);

   dsw_checker u_checker (.*);

   // pick a gap: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // one beat on the input channel, then a random gap if with_gap is set
   task automatic send_sum(input logic [dsw_pkg::SumW-1:0] t, input bit with_gap);
      int g;
      req_valid <= 1'b1;
      req_target_sum <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      g = with_gap ? pick_gap() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // receiver stall pattern; hold_off overrides it for the long stretch
   initial begin
      int g;
      forever begin
         @(posedge clock);
         if (hold_off) rsp_stall <= 1'b1;
         else begin
            g = pick_gap();
            if (g > 0 && $urandom_range(0, 3) == 0) begin
               rsp_stall <= 1'b1;
               repeat (g - 1) @(posedge clock);
               if (!hold_off) rsp_stall <= 1'b0;
            end else rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #20000000;
      $display("dice_sum_ways_count_core regression: fail");
      $finish;
   end

   initial begin
      int s, n, mode, t;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset config (6 sides, 2 dice), extremes of the sum
      send_sum(8'd0, 1); send_sum(8'd1, 1); send_sum(8'd2, 1); send_sum(8'd7, 1);
      send_sum(8'd12, 1); send_sum(8'd13, 1); send_sum(8'hAA, 1); send_sum(8'h55, 1);
      send_sum(8'd255, 0);
      drain();
      // sides zero and dice zero fold to one
      write_reg(dsw_pkg::AddrSides, 32'd0); write_reg(dsw_pkg::AddrDice, 32'd0);
      send_sum(8'd0, 1); send_sum(8'd1, 1); send_sum(8'd2, 0);
      drain();
      // sides and dice above the limits clamp; top bits of the data set
      write_reg(dsw_pkg::AddrSides, 32'hFFFF_FFFF); write_reg(dsw_pkg::AddrDice, 32'hFFFF_FFFF);
      send_sum(8'd8, 1); send_sum(8'd132, 1); send_sum(8'd255, 1); send_sum(8'd7, 0);
      drain();
      // largest in-range configuration
      write_reg(dsw_pkg::AddrSides, 32'd32); write_reg(dsw_pkg::AddrDice, 32'd8);
      send_sum(8'd8, 1); send_sum(8'd136, 1); send_sum(8'd255, 1); send_sum(8'd9, 0);
      drain();

      // long receiver hold-off while items keep coming, so the input stalls
      hold_off <= 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off <= 1'b0;
         end
         for (int i = 0; i < 6; i++) send_sum(8'($urandom_range(8, 136)), 0);
      join
      drain();

      // random phases
      for (int ph = 0; ph < 28; ph++) begin
         mode = $urandom_range(0, 9);
         s = (mode == 0) ? 63 : (mode == 1) ? 1 : (mode < 4) ? $urandom_range(0, 63)
             : $urandom_range(1, 12);
         n = (mode == 0) ? 15 : (mode == 1) ? 1 : (mode < 4) ? $urandom_range(0, 15)
             : $urandom_range(1, 4);
         write_reg(dsw_pkg::AddrSides, {$urandom} & 32'hFFFF_FFC0 | 32'(s));
         write_reg(dsw_pkg::AddrDice, {$urandom} & 32'hFFFF_FFF0 | 32'(n));
         if (s == 0) s = 1; if (s > dsw_pkg::MaxSides) s = dsw_pkg::MaxSides;
         if (n == 0) n = 1; if (n > dsw_pkg::MaxDice) n = dsw_pkg::MaxDice;
         for (int i = 0; i < 50; i++) begin
            if ($urandom_range(0, 4) != 0) t = $urandom_range(n, s * n);
            else t = $urandom_range(0, 255);
            send_sum(8'(t), 1);
         end
         drain();   // sender pauses until all results are back
      end

      if (fail_count == 0) $display("dice_sum_ways_count_core regression: pass");
      else $display("dice_sum_ways_count_core regression: fail");
      $finish;
   end
endmodule
